// ----- hdl/tsrs_pkg.sv -----
// Package for the triggered servo ramp sequencer: field widths, register
// indexes, reset values and the request/response types of the ramp divider.
// No dependencies.
`default_nettype none

package tsrs_pkg;

    // Field and register widths
    localparam int PW_W    = 12;   // pulse widths in microseconds
    localparam int HOLD_W  = 16;   // hold length and tick counter
    localparam int STEP_W  = 8;    // step length, step count, step index
    localparam int DEB_W   = 8;    // debounce limit and counter
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd5;

    // Reset values
    localparam logic [PW_W-1:0]   RST_PULSE_LOW  = 12'd500;
    localparam logic [PW_W-1:0]   RST_PULSE_HIGH = 12'd1000;
    localparam logic [HOLD_W-1:0] RST_HOLD       = 16'd17000;
    localparam logic [STEP_W-1:0] RST_STEP       = 8'd10;
    localparam logic [STEP_W-1:0] RST_RAMP_STEPS = 8'd40;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE   = 8'd50;

    // Ramp divider: |delta| * step over ramp_steps
    localparam int DVD_W       = PW_W + STEP_W;
    localparam int DIV_BITS    = 2;                    // quotient bits per cycle
    localparam int DIV_CYCLES  = DVD_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hdl/tsrs_if.sv -----
// Channel interfaces of the sequencer: tick input, result output and
// configuration write. Depends on tsrs_pkg.
`default_nettype none

interface tsrs_in_if;
    import tsrs_pkg::*;
    logic valid;
    logic ready;
    logic sensor_level;
    modport source (output valid, output sensor_level, input ready);
    modport sink   (input valid, input sensor_level, output ready);
endinterface

interface tsrs_out_if;
    import tsrs_pkg::*;
    logic            valid;
    logic            ready;
    logic [PW_W-1:0] pulse_width_us;
    logic            busy_res;
    logic            trigger_seen;
    modport source (output valid, output pulse_width_us, output busy_res,
                    output trigger_seen, input ready);
    modport sink   (input valid, input pulse_width_us, input busy_res,
                    input trigger_seen, output ready);
endinterface

interface tsrs_cfg_if;
    import tsrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/triggered_servo_ramp_sequencer_unit.sv -----
// Top level of the triggered servo ramp sequencer: debounce, phase sequencer,
// ramp interpolation and output register. Depends on tsrs_pkg, tsrs_if.sv
// and tsrs_div.
//
// Use:
//  - i_in carries one millisecond tick per transfer with the raw active-low
//    sensor level. o_out returns exactly one result per tick: pulse width,
//    busy flag and the debounce confirmation flag.
//  - i_cfg writes the six registers (index 0..5: pulse low, pulse high, hold,
//    step length, ramp steps, debounce). It is always ready; indexes 6 and 7
//    are ignored. Write only while no tick is in flight.
//  - Flow: i_in.ready is high only in the idle state, so a new tick is taken
//    only once the previous result is in the output register. A tick that
//    lands on an intermediate ramp step goes through ST_MUL, where the
//    |delta| * step product is registered in the divider, and ST_DIV, where
//    the divider works two quotient bits a cycle over the 20-bit dividend
//    and the quotient is then applied, before ST_DONE loads the output
//    register; any other tick goes straight to ST_DONE.
//  - The result sits in an output register; if the receiver stalls, the
//    sequencer finishes the next tick and then waits for the register to
//    free, holding i_in.ready low meanwhile.
//  - Reset (synchronous, active low) restores the register defaults, idle
//    phase, a 500 us pulse, cleared counters and the released sensor flag.
`default_nettype none

module triggered_servo_ramp_sequencer_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tsrs_in_if.sink     i_in,
    tsrs_out_if.source  o_out,
    tsrs_cfg_if.sink    i_cfg
);
    import tsrs_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Servo phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;
    localparam logic [1:0] PH_DOWN = 2'd3;

    // Configuration registers
    logic [PW_W-1:0]   r_pulse_low;
    logic [PW_W-1:0]   r_pulse_high;
    logic [HOLD_W-1:0] r_hold;
    logic [STEP_W-1:0] r_step_ms;
    logic [STEP_W-1:0] r_ramp_steps;
    logic [DEB_W-1:0]  r_debounce;

    // Architectural state
    logic [1:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [PW_W-1:0]   r_pulse, n_pulse;
    logic [HOLD_W-1:0] r_tick, n_tick;
    logic [STEP_W-1:0] r_step_idx, n_step_idx;
    logic [DEB_W-1:0]  r_deb_cnt, n_deb_cnt;
    logic              r_released, n_released;
    logic              r_trig, n_trig;

    // Interpolation operands
    logic [PW_W-1:0]   r_from, n_from;
    logic [PW_W-1:0]   r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [STEP_W-1:0] r_istep, n_istep;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [PW_W-1:0]   r_out_pw, n_out_pw;
    logic              r_out_busy, n_out_busy;
    logic              r_out_trig, n_out_trig;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_xfer;
    logic out_xfer;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = o_out.valid && o_out.ready;
    assign i_cfg.ready = 1'b1;

    // Ramp interpolation divider
    tsrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        logic [DEB_W-1:0]  deb_inc;
        logic [HOLD_W-1:0] tick_inc;
        logic [STEP_W-1:0] step_inc;
        logic [PW_W-1:0]   ramp_from, ramp_to;
        logic              interp;
        logic [PW_W-1:0]   quo;

        n_state     = r_state;
        n_phase     = r_phase;
        n_pulse     = r_pulse;
        n_tick      = r_tick;
        n_step_idx  = r_step_idx;
        n_deb_cnt   = r_deb_cnt;
        n_released  = r_released;
        n_trig      = r_trig;
        n_from      = r_from;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_istep     = r_istep;
        n_out_valid = r_out_valid && !out_xfer;
        n_out_pw    = r_out_pw;
        n_out_busy  = r_out_busy;
        n_out_trig  = r_out_trig;

        div_req.start    = 1'b0;
        div_req.dividend = r_mag * r_istep;   // 12 x 8 product, registered in the divider
        div_req.divisor  = r_ramp_steps;

        deb_inc   = r_deb_cnt + 1'b1;
        tick_inc  = r_tick + 1'b1;
        step_inc  = r_step_idx + 1'b1;
        ramp_from = (r_phase == PH_UP) ? r_pulse_low : r_pulse_high;
        ramp_to   = (r_phase == PH_UP) ? r_pulse_high : r_pulse_low;
        interp    = 1'b0;
        quo       = div_rsp.quotient[PW_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    // Debounce: a run of low ticks confirms once per press
                    n_trig = 1'b0;
                    if (!i_in.sensor_level) begin
                        if (r_deb_cnt < r_debounce) begin
                            n_deb_cnt = deb_inc;
                            if (deb_inc == r_debounce) begin
                                n_trig     = r_released;
                                n_released = 1'b0;
                            end
                        end
                    end else begin
                        n_deb_cnt  = '0;
                        n_released = 1'b1;
                    end

                    unique case (r_phase)
                        PH_IDLE: begin
                            n_pulse = r_pulse_low;
                            if (n_trig) begin
                                n_phase    = PH_UP;
                                n_step_idx = '0;
                                n_tick     = '0;
                            end
                        end
                        PH_HOLD: begin
                            n_pulse = r_pulse_high;
                            if (tick_inc >= r_hold) begin
                                n_step_idx = '0;
                                n_tick     = '0;
                                n_phase    = PH_DOWN;
                            end else begin
                                n_tick = tick_inc;
                            end
                        end
                        default: begin
                            // Ramp up or down
                            if (tick_inc < {{(HOLD_W-STEP_W){1'b0}}, r_step_ms}) begin
                                n_tick = tick_inc;
                            end else begin
                                n_tick = '0;
                                if (step_inc >= r_ramp_steps) begin
                                    n_pulse    = ramp_to;
                                    n_step_idx = '0;
                                    n_phase    = (r_phase == PH_UP) ? PH_HOLD : PH_IDLE;
                                end else begin
                                    n_step_idx = step_inc;
                                    interp     = 1'b1;
                                    n_from     = ramp_from;
                                    n_neg      = (ramp_to < ramp_from);
                                    n_mag      = (ramp_to < ramp_from) ? (ramp_from - ramp_to)
                                                                       : (ramp_to - ramp_from);
                                    n_istep    = step_inc;
                                end
                            end
                        end
                    endcase
                    n_state = interp ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                div_req.start = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    // Quotient never exceeds |delta|, so no wrap either way
                    n_pulse = r_neg ? (r_from - quo) : (r_from + quo);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_pw    = r_pulse;
                    n_out_busy  = (r_phase != PH_IDLE);
                    n_out_trig  = r_trig;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_low  <= RST_PULSE_LOW;
            r_pulse_high <= RST_PULSE_HIGH;
            r_hold       <= RST_HOLD;
            r_step_ms    <= RST_STEP;
            r_ramp_steps <= RST_RAMP_STEPS;
            r_debounce   <= RST_DEBOUNCE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_PULSE_LOW:  r_pulse_low  <= i_cfg.data[PW_W-1:0];
                REG_PULSE_HIGH: r_pulse_high <= i_cfg.data[PW_W-1:0];
                REG_HOLD:       r_hold       <= i_cfg.data[HOLD_W-1:0];
                REG_STEP:       r_step_ms    <= i_cfg.data[STEP_W-1:0];
                REG_RAMP_STEPS: r_ramp_steps <= i_cfg.data[STEP_W-1:0];
                REG_DEBOUNCE:   r_debounce   <= i_cfg.data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_pulse     <= RST_PULSE_LOW;
            r_tick      <= '0;
            r_step_idx  <= '0;
            r_deb_cnt   <= '0;
            r_released  <= 1'b1;
            r_trig      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pulse     <= n_pulse;
            r_tick      <= n_tick;
            r_step_idx  <= n_step_idx;
            r_deb_cnt   <= n_deb_cnt;
            r_released  <= n_released;
            r_trig      <= n_trig;
            r_out_valid <= n_out_valid;
        end
        r_from     <= n_from;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_istep    <= n_istep;
        r_out_pw   <= n_out_pw;
        r_out_busy <= n_out_busy;
        r_out_trig <= n_out_trig;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pulse_width_us = r_out_pw;
    assign o_out.busy_res       = r_out_busy;
    assign o_out.trigger_seen   = r_out_trig;

endmodule

`default_nettype wire

// ----- hdl/tsrs_div.sv -----
// Iterative restoring divider for the ramp interpolation, two quotient bits
// per cycle. Depends on tsrs_pkg.
`default_nettype none

module tsrs_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tsrs_pkg::t_div_req  i_req,
    output tsrs_pkg::t_div_rsp  o_rsp
);
    import tsrs_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [STEP_W-1:0]    r_rem, n_rem;
    logic [DVD_W-1:0]     r_quo, n_quo;
    logic [STEP_W-1:0]    r_div;

    always_comb begin
        logic [STEP_W:0]    t;
        logic [STEP_W-1:0]  rem;
        logic [DVD_W-1:0]   quo;
        logic               ge;
        t      = '0;
        ge     = 1'b0;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        rem    = r_rem;
        quo    = r_quo;
        if (r_busy) begin
            for (int k = 0; k < DIV_BITS; k++) begin
                t   = {rem, quo[DVD_W-1]};
                ge  = (t >= {1'b0, r_div});
                t   = ge ? (t - {1'b0, r_div}) : t;
                rem = t[STEP_W-1:0];
                quo = {quo[DVD_W-2:0], ge};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        n_rem = rem;
        n_quo = quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) begin
            r_div <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench for triggered_servo_ramp_sequencer_unit: millisecond ticks in,
// one pulse/busy/trigger result out per tick, checked against an in-bench predictor.
// Depends on hdl/tsrs_pkg.sv, hdl/tsrs_if.sv and the RTL of the unit.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsrs_pkg::*;

    // Indexes past the six registers; the unit must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int TICK_TARGET = 1750;  // stimulus stops once this many ticks are queued
    localparam int QUIET_LIMIT = 4000;  // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 20;    // settle time after the last result

    typedef enum logic [1:0] {
        SEQ_IDLE      = 2'd0,
        SEQ_RAMP_UP   = 2'd1,
        SEQ_HOLD      = 2'd2,
        SEQ_RAMP_DOWN = 2'd3
    } t_seq_phase;

    typedef struct packed {
        logic [PW_W-1:0] pulse_us;
        logic            busy;
        logic            fired;
    } t_servo_result;

    logic i_clk;
    logic i_rst_n;

    tsrs_in_if  tick_bus ();
    tsrs_out_if result_bus ();
    tsrs_cfg_if reg_bus ();

    triggered_servo_ramp_sequencer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_bus),
        .o_out   (result_bus),
        .i_cfg   (reg_bus)
    );

    // ------------------------------------------------------------------
    // Predictor: register copy and sequencer state, starting from reset
    // ------------------------------------------------------------------
    logic [PW_W-1:0]   cfg_pulse_low  = RST_PULSE_LOW;
    logic [PW_W-1:0]   cfg_pulse_high = RST_PULSE_HIGH;
    logic [HOLD_W-1:0] cfg_hold_ms    = RST_HOLD;
    logic [STEP_W-1:0] cfg_step_ms    = RST_STEP;
    logic [STEP_W-1:0] cfg_ramp_steps = RST_RAMP_STEPS;
    logic [DEB_W-1:0]  cfg_debounce   = RST_DEBOUNCE;

    t_seq_phase        seq_phase = SEQ_IDLE;
    logic [PW_W-1:0]   pulse_now = RST_PULSE_LOW;
    logic [HOLD_W-1:0] tick_cnt  = '0;
    logic [STEP_W-1:0] step_idx  = '0;
    logic [DEB_W-1:0]  deb_cnt   = '0;
    logic              released  = 1'b1;

    // Bench bookkeeping
    logic          sensor_ticks[$];        // sensor levels waiting for the driver
    t_servo_result pulse_results_due[$];   // predicted results, oldest first
    logic          tick_pending = 1'b0;    // a tick is on the bus, not yet transferred
    logic          steady_flow  = 1'b0;    // no gaps on either side in this stretch
    int            gap_left     = 0;
    int            stall_left   = 0;
    int            fault_count  = 0;
    int            quiet_cycles = 0;
    int            ticks_queued = 0;

    // Mostly back-to-back, sometimes a few cycles, now and then a long pause
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void note_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("mismatch: %s", what);
    endfunction

    // One ramp tick; true once the ramp has reached its end value.
    // Intermediate points: first + (last - first) * step / steps, truncated to zero.
    function automatic logic ramp_advance(input logic [PW_W-1:0] first_us,
                                          input logic [PW_W-1:0] last_us);
        int span;
        int level;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt < cfg_step_ms) return 1'b0;
        tick_cnt = '0;
        step_idx = step_idx + 1'b1;
        // Zero steps lands here at once, so the divide below never sees zero
        if (step_idx >= cfg_ramp_steps) begin
            pulse_now = last_us;
            step_idx  = '0;
            return 1'b1;
        end
        span  = int'(last_us) - int'(first_us);
        level = int'(first_us) + (span * int'(step_idx)) / int'(cfg_ramp_steps);
        if (level < 0) level = 0;
        pulse_now = level[PW_W-1:0];
        return 1'b0;
    endfunction

    // Advance the predictor by one tick and return the result it produces
    function automatic t_servo_result advance_servo(input logic level);
        t_servo_result res;
        logic          fired;
        fired = 1'b0;
        // Debounce: count low ticks up to the limit; one pulse per press.
        // A count already at or past a lowered limit stays put and fires nothing.
        if (!level) begin
            if (deb_cnt < cfg_debounce) begin
                deb_cnt = deb_cnt + 1'b1;
                if (deb_cnt == cfg_debounce) begin
                    if (released) fired = 1'b1;
                    released = 1'b0;
                end
            end
        end else begin
            deb_cnt  = '0;
            released = 1'b1;
        end

        case (seq_phase)
            SEQ_IDLE: begin
                pulse_now = cfg_pulse_low;
                if (fired) begin
                    seq_phase = SEQ_RAMP_UP;
                    step_idx  = '0;
                    tick_cnt  = '0;
                end
            end
            SEQ_RAMP_UP: begin
                if (ramp_advance(cfg_pulse_low, cfg_pulse_high)) begin
                    tick_cnt  = '0;
                    seq_phase = SEQ_HOLD;
                end
            end
            SEQ_HOLD: begin
                pulse_now = cfg_pulse_high;
                tick_cnt  = tick_cnt + 1'b1;
                if (tick_cnt >= cfg_hold_ms) begin
                    step_idx  = '0;
                    tick_cnt  = '0;
                    seq_phase = SEQ_RAMP_DOWN;
                end
            end
            default: begin
                if (ramp_advance(cfg_pulse_high, cfg_pulse_low)) begin
                    tick_cnt  = '0;
                    seq_phase = SEQ_IDLE;
                end
            end
        endcase

        // A trigger outside idle still shows in the flag, but starts nothing
        res.pulse_us = pulse_now;
        res.busy     = (seq_phase != SEQ_IDLE);
        res.fired    = fired;
        return res;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] word);
        case (idx)
            REG_PULSE_LOW:  cfg_pulse_low  = word[PW_W-1:0];
            REG_PULSE_HIGH: cfg_pulse_high = word[PW_W-1:0];
            REG_HOLD:       cfg_hold_ms    = word[HOLD_W-1:0];
            REG_STEP:       cfg_step_ms    = word[STEP_W-1:0];
            REG_RAMP_STEPS: cfg_ramp_steps = word[STEP_W-1:0];
            REG_DEBOUNCE:   cfg_debounce   = word[DEB_W-1:0];
            default: ;
        endcase
    endfunction

    // Zero, the all-ones extreme, or something ordinary
    function automatic int unsigned pick_setting(input int width, input int unsigned typical);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return (1 << width) - 1;
        return $urandom_range(1, typical);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tick driver: presents queued sensor levels at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!tick_pending) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                tick_bus.valid        <= 1'b0;
                tick_bus.sensor_level <= 1'($urandom);
            end else if (sensor_ticks.size() != 0) begin
                // valid may already be high from the last transfer: one assignment only
                tick_bus.valid        <= 1'b1;
                tick_bus.sensor_level <= sensor_ticks.pop_front();
                tick_pending = 1'b1;
                gap_left     = steady_flow ? 0 : pick_gap();
            end else begin
                tick_bus.valid        <= 1'b0;
                tick_bus.sensor_level <= 1'($urandom);
            end
        end
    end

    // Result sink: random back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            result_bus.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            result_bus.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each tick transfer, checks each result transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_servo_result due;
        if (i_rst_n && tick_bus.valid && tick_bus.ready) begin
            pulse_results_due.push_back(advance_servo(tick_bus.sensor_level));
            tick_pending = 1'b0;
        end
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pulse_results_due.size() == 0) begin
                note_fault($sformatf("result with nothing due: pulse %0d busy %0b trig %0b",
                                     result_bus.pulse_width_us, result_bus.busy_res,
                                     result_bus.trigger_seen));
            end else begin
                due = pulse_results_due.pop_front();
                if (result_bus.pulse_width_us !== due.pulse_us ||
                    result_bus.busy_res !== due.busy ||
                    result_bus.trigger_seen !== due.fired) begin
                    note_fault($sformatf(
                        "pulse exp %0d got %0d, busy exp %0b got %0b, trig exp %0b got %0b",
                        due.pulse_us, result_bus.pulse_width_us, due.busy,
                        result_bus.busy_res, due.fired, result_bus.trigger_seen));
                end
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress
    always @(posedge i_clk) begin
        if ((tick_bus.valid && tick_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (reg_bus.valid && reg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sender pause: nothing queued, nothing on the bus, every result back
    task automatic wait_drained();
        while (sensor_ticks.size() != 0 || tick_pending || pulse_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; bits above the register width are sometimes junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
        int unsigned           keep;
        logic [CFG_DATA_W-1:0] word;
        keep = (width >= 32) ? 32'hFFFF_FFFF : ((1 << width) - 1);
        word = CFG_DATA_W'(($urandom_range(0, 1) == 0) ? value
                                                       : (($urandom & ~keep) | (value & keep)));
        @(negedge i_clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= word;
        do @(posedge i_clk); while (!reg_bus.ready);
        store_register(idx, word);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        reg_bus.valid <= 1'b0;
    endtask

    // Directed levels, oldest tick in the top bit
    task automatic queue_levels(input logic [31:0] bits, input int count);
        for (int b = count - 1; b >= 0; b--) sensor_ticks.push_back(bits[b]);
        ticks_queued += count;
    endtask

    // Mostly full presses (low for at least the debounce length, then released),
    // some presses cut short, some raw noise
    task automatic queue_presses(input int unsigned count);
        int unsigned made;
        int unsigned lows;
        int unsigned highs;
        int          kind;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                lows = cfg_debounce + $urandom_range(0, 3);
                if (kind == 6 && cfg_debounce > 1) lows = $urandom_range(1, cfg_debounce - 1);
                highs = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
                repeat (lows) sensor_ticks.push_back(1'b0);
                repeat (highs) sensor_ticks.push_back(1'b1);
                made += lows + highs;
            end else begin
                lows = $urandom_range(1, 8);
                repeat (lows) sensor_ticks.push_back(1'($urandom));
                made += lows;
            end
        end
        ticks_queued += made;
    endtask

    // New settings for the next stretch; the sequencer may be mid-ramp or mid-hold
    task automatic shuffle_registers();
        if ($urandom_range(0, 1)) write_reg(REG_PULSE_LOW, pick_setting(PW_W, 4095), PW_W);
        if ($urandom_range(0, 1)) write_reg(REG_PULSE_HIGH, pick_setting(PW_W, 4095), PW_W);
        if ($urandom_range(0, 1)) write_reg(REG_HOLD, pick_setting(HOLD_W, 30), HOLD_W);
        if ($urandom_range(0, 1)) write_reg(REG_STEP, pick_setting(STEP_W, 3), STEP_W);
        if ($urandom_range(0, 1)) write_reg(REG_RAMP_STEPS, pick_setting(STEP_W, 8), STEP_W);
        if ($urandom_range(0, 1)) write_reg(REG_DEBOUNCE, pick_setting(DEB_W, 6), DEB_W);
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_LO, $urandom, 0);
        if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_HI, $urandom, 0);
        end_writes();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        tick_bus.valid        = 1'b0;
        tick_bus.sensor_level = 1'b1;
        result_bus.ready      = 1'b0;
        reg_bus.valid         = 1'b0;
        reg_bus.index         = REG_PULSE_LOW;
        reg_bus.data          = '0;
        i_rst_n               = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: idle at 500 us, debounce of 50 far from reached
        queue_levels(3'b101, 3);

        // Full-scale ramps in three steps, one-tick hold; a press during the
        // down ramp is flagged but lost; ends with a new sequence under way
        wait_drained();
        write_reg(REG_PULSE_LOW, 0, PW_W);
        write_reg(REG_PULSE_HIGH, 4095, PW_W);
        write_reg(REG_HOLD, 1, HOLD_W);
        write_reg(REG_STEP, 1, STEP_W);
        write_reg(REG_RAMP_STEPS, 3, STEP_W);
        write_reg(REG_DEBOUNCE, 1, DEB_W);
        end_writes();
        queue_levels(10'b1000010110, 10);

        // Changed mid-ramp: zero steps, zero step length, zero hold, and the
        // pulse limits swapped so the "up" ramp goes down
        wait_drained();
        write_reg(REG_PULSE_LOW, 4095, PW_W);
        write_reg(REG_PULSE_HIGH, 0, PW_W);
        write_reg(REG_HOLD, 0, HOLD_W);
        write_reg(REG_STEP, 0, STEP_W);
        write_reg(REG_RAMP_STEPS, 0, STEP_W);
        write_reg(REG_DEBOUNCE, 2, DEB_W);
        end_writes();
        queue_levels(6'b111000, 6);

        // Debounce of zero never confirms
        wait_drained();
        write_reg(REG_DEBOUNCE, 0, DEB_W);
        end_writes();
        queue_levels(4'b0010, 4);

        // Debounce lowered below a running count: silent until released
        wait_drained();
        write_reg(REG_PULSE_LOW, 100, PW_W);
        write_reg(REG_PULSE_HIGH, 3000, PW_W);
        write_reg(REG_HOLD, 2, HOLD_W);
        write_reg(REG_STEP, 2, STEP_W);
        write_reg(REG_RAMP_STEPS, 5, STEP_W);
        write_reg(REG_DEBOUNCE, 3, DEB_W);
        write_reg(REG_SPARE_LO, 16'hFFFF, 0);
        write_reg(REG_SPARE_HI, 16'h5A5A, 0);
        end_writes();
        queue_levels(2'b00, 2);
        wait_drained();
        write_reg(REG_DEBOUNCE, 1, DEB_W);
        end_writes();
        queue_levels(3'b010, 3);

        // Random stretches, each under fresh settings written while drained
        while (ticks_queued < TICK_TARGET) begin
            wait_drained();
            shuffle_registers();
            steady_flow = ($urandom_range(0, 3) == 0);
            queue_presses($urandom_range(30, 120));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pulse_results_due.size() != 0)
            note_fault($sformatf("%0d results never arrived", pulse_results_due.size()));
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/tsrs_pkg.sv
hdl/tsrs_if.sv
hdl/tsrs_div.sv
hdl/triggered_servo_ramp_sequencer_unit.sv
sim/testbench.sv
